[sv/uart_interrupt_transfer_control_defines.svh]
// ---------------------------------------------------------------------------
// UART interrupt transfer control assertion macros
// Shared assertion forms for the transfer control RTL.
// ---------------------------------------------------------------------------
`ifndef UART_INTERRUPT_TRANSFER_CONTROL_DEFINES_SVH
`define UART_INTERRUPT_TRANSFER_CONTROL_DEFINES_SVH

// same-cycle implication
`define UITC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uitc assertion failed");

// next-cycle implication
`define UITC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uitc assertion failed");

`endif

[sv/uitc_pkg.sv]
// ---------------------------------------------------------------------------
// UART interrupt transfer control package
// Types, codes and helpers shared by the transfer control modules.
// ---------------------------------------------------------------------------
package uitc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_START_TX = 2'd0,
        CMD_START_RX = 2'd1,
        CMD_EVENT    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_NINE_BIT_WORDS   = 3'd0,
        REG_PARITY_ENABLED   = 3'd1,
        REG_CTS_FLOW_ENABLED = 3'd2,
        REG_CTS_IRQ_ENABLED  = 3'd3,
        REG_IDLE_IRQ_ENABLED = 3'd4
    } reg_idx_t;

    localparam logic [8:0] MASK_9BIT = 9'h1FF;
    localparam logic [8:0] MASK_8BIT = 9'h0FF;
    localparam logic [8:0] MASK_7BIT = 9'h07F;

    typedef struct packed {
        logic nine_bit_words;
        logic parity_enabled;
        logic cts_flow_enabled;
        logic cts_irq_enabled;
        logic idle_irq_enabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0] tx_remaining;
        logic [7:0] rx_remaining;
        logic       tx_active;
        logic       rx_active;
        logic       txe_irq_armed;
        logic       tc_irq_armed;
        logic       rxne_irq_armed;
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  length;
        logic        flag_tc;
        logic        flag_txe;
        logic        flag_rxne;
        logic        flag_cts;
        logic        flag_idle;
        logic        flag_overrun;
        logic [15:0] tx_element;
        logic [8:0]  rx_word;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [8:0] tx_data;
        logic       rx_valid;
        logic [8:0] rx_data;
        logic       tx_done;
        logic       rx_done;
        logic       cts_event;
        logic       idle_event;
        logic       overrun_event;
        logic       tx_busy;
        logic       rx_busy;
    } result_t;

    function automatic logic [7:0] count_down(input logic [7:0] n, input logic [1:0] step);
        logic [7:0] s;
        s = {6'b0, step};
        return (n > s) ? (n - s) : 8'd0;
    endfunction

endpackage

[sv/uart_interrupt_transfer_control.sv]
// ---------------------------------------------------------------------------
// UART interrupt transfer control
// Interrupt-driven UART transfer controller with APB configuration.
// ---------------------------------------------------------------------------
// One request is taken per clock while in_ready is high. Its result appears in
// the output register on the next cycle and stays there until taken; in_ready
// is low only while a result is waiting and out_ready is low. The step logic is
// a single pass of flag checks and a byte counter update between the state and
// result registers, so with out_ready high the rate is one request per cycle.
module uart_interrupt_transfer_control (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uitc_pkg::ADDR_W-1:0] paddr,
    input  logic [uitc_pkg::DATA_W-1:0] pwdata,
    output logic [uitc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [7:0]                  length,
    input  logic                        flag_tc,
    input  logic                        flag_txe,
    input  logic                        flag_rxne,
    input  logic                        flag_cts,
    input  logic                        flag_idle,
    input  logic                        flag_overrun,
    input  logic [15:0]                 tx_element,
    input  logic [8:0]                  rx_word,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        tx_valid,
    output logic [8:0]                  tx_data,
    output logic                        rx_valid,
    output logic [8:0]                  rx_data,
    output logic                        tx_done,
    output logic                        rx_done,
    output logic                        cts_event,
    output logic                        idle_event,
    output logic                        overrun_event,
    output logic                        tx_busy,
    output logic                        rx_busy
);

`include "uart_interrupt_transfer_control_defines.svh"

    uitc_pkg::cfg_t    cfg_reg;
    uitc_pkg::cfg_t    cfg_next;
    uitc_pkg::state_t  state_reg;
    uitc_pkg::state_t  state_next;
    uitc_pkg::item_t   item;
    uitc_pkg::result_t result_reg;
    uitc_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              accept;
    logic              cfg_write;
    uitc_pkg::reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = uitc_pkg::reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                uitc_pkg::REG_NINE_BIT_WORDS:   cfg_next.nine_bit_words   = pwdata[0];
                uitc_pkg::REG_PARITY_ENABLED:   cfg_next.parity_enabled   = pwdata[0];
                uitc_pkg::REG_CTS_FLOW_ENABLED: cfg_next.cts_flow_enabled = pwdata[0];
                uitc_pkg::REG_CTS_IRQ_ENABLED:  cfg_next.cts_irq_enabled  = pwdata[0];
                uitc_pkg::REG_IDLE_IRQ_ENABLED: cfg_next.idle_irq_enabled = pwdata[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            uitc_pkg::REG_NINE_BIT_WORDS:   prdata[0] = cfg_reg.nine_bit_words;
            uitc_pkg::REG_PARITY_ENABLED:   prdata[0] = cfg_reg.parity_enabled;
            uitc_pkg::REG_CTS_FLOW_ENABLED: prdata[0] = cfg_reg.cts_flow_enabled;
            uitc_pkg::REG_CTS_IRQ_ENABLED:  prdata[0] = cfg_reg.cts_irq_enabled;
            uitc_pkg::REG_IDLE_IRQ_ENABLED: prdata[0] = cfg_reg.idle_irq_enabled;
            default:                        prdata    = '0;
        endcase
    end

    assign item.command      = command;
    assign item.length       = length;
    assign item.flag_tc      = flag_tc;
    assign item.flag_txe     = flag_txe;
    assign item.flag_rxne    = flag_rxne;
    assign item.flag_cts     = flag_cts;
    assign item.flag_idle    = flag_idle;
    assign item.flag_overrun = flag_overrun;
    assign item.tx_element   = tx_element;
    assign item.rx_word      = rx_word;

    uitc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_valid      = result_reg.tx_valid;
    assign tx_data       = result_reg.tx_data;
    assign rx_valid      = result_reg.rx_valid;
    assign rx_data       = result_reg.rx_data;
    assign tx_done       = result_reg.tx_done;
    assign rx_done       = result_reg.rx_done;
    assign cts_event     = result_reg.cts_event;
    assign idle_event    = result_reg.idle_event;
    assign overrun_event = result_reg.overrun_event;
    assign tx_busy       = result_reg.tx_busy;
    assign rx_busy       = result_reg.rx_busy;

    // receive arming tracks receive activity exactly
    `UITC_ASSERT_NOW(a_rx_arm_tracks_active, 1'b1, state_reg.rxne_irq_armed == state_reg.rx_active)
    // an accepted request always leaves a result behind
    `UITC_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg)
    // idle transmit start loads the count and goes busy
    `UITC_ASSERT_NEXT(a_tx_start_loads,
        accept && command == uitc_pkg::CMD_START_TX && !state_reg.tx_active,
        state_reg.tx_active && state_reg.tx_remaining == $past(length) && tx_busy)
    // a finished receive is never reported busy
    `UITC_ASSERT_NOW(a_rx_done_not_busy, out_valid_reg && result_reg.rx_done, !result_reg.rx_busy)

endmodule

[sv/uitc_step.sv]
// ---------------------------------------------------------------------------
// UART interrupt transfer control step logic
// Next state and result for one request, from the current state and config.
// ---------------------------------------------------------------------------
module uitc_step (
    input  uitc_pkg::cfg_t    cfg,
    input  uitc_pkg::state_t  state,
    input  uitc_pkg::item_t   item,
    output uitc_pkg::state_t  state_next,
    output uitc_pkg::result_t result
);

    always_comb
    begin
        uitc_pkg::state_t  st;
        uitc_pkg::result_t r;
        logic [1:0]        tx_step;
        logic [1:0]        rx_step;

        st = state;
        r  = '0;
        tx_step = (cfg.nine_bit_words && !cfg.parity_enabled) ? 2'd2 : 2'd1;
        rx_step = tx_step;

        unique case (uitc_pkg::cmd_t'(item.command))
            uitc_pkg::CMD_START_TX:
            begin
                if (!st.tx_active)
                begin
                    st.tx_remaining  = item.length;
                    st.tx_active     = 1'b1;
                    st.txe_irq_armed = 1'b1;
                    st.tc_irq_armed  = 1'b1;
                end
            end
            uitc_pkg::CMD_START_RX:
            begin
                if (!st.rx_active)
                begin
                    st.rx_remaining   = item.length;
                    st.rx_active      = 1'b1;
                    st.rxne_irq_armed = 1'b1;
                end
            end
            uitc_pkg::CMD_EVENT:
            begin
                // completion is judged before this request's send
                if (item.flag_tc && st.tc_irq_armed && st.tx_active && st.tx_remaining == 8'd0)
                begin
                    st.tc_irq_armed = 1'b0;
                    st.tx_active    = 1'b0;
                    r.tx_done       = 1'b1;
                end
                if (item.flag_txe && st.txe_irq_armed && st.tx_active)
                begin
                    if (st.tx_remaining != 8'd0)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_data  = cfg.nine_bit_words ? (item.tx_element[8:0] & uitc_pkg::MASK_9BIT)
                                                        : {1'b0, item.tx_element[7:0]};
                        st.tx_remaining = uitc_pkg::count_down(st.tx_remaining, tx_step);
                    end
                    if (st.tx_remaining == 8'd0)
                    begin
                        st.txe_irq_armed = 1'b0;
                    end
                end
                if (item.flag_rxne && st.rxne_irq_armed && st.rx_active)
                begin
                    if (st.rx_remaining != 8'd0)
                    begin
                        r.rx_valid = 1'b1;
                        if (cfg.nine_bit_words && !cfg.parity_enabled)
                        begin
                            r.rx_data = item.rx_word & uitc_pkg::MASK_9BIT;
                        end
                        else if (!cfg.nine_bit_words && cfg.parity_enabled)
                        begin
                            r.rx_data = item.rx_word & uitc_pkg::MASK_7BIT;
                        end
                        else
                        begin
                            r.rx_data = item.rx_word & uitc_pkg::MASK_8BIT;
                        end
                        st.rx_remaining = uitc_pkg::count_down(st.rx_remaining, rx_step);
                    end
                    if (st.rx_remaining == 8'd0)
                    begin
                        st.rxne_irq_armed = 1'b0;
                        st.rx_active      = 1'b0;
                        r.rx_done         = 1'b1;
                    end
                end
                r.cts_event     = item.flag_cts && cfg.cts_irq_enabled && cfg.cts_flow_enabled;
                r.idle_event    = item.flag_idle && cfg.idle_irq_enabled;
                r.overrun_event = item.flag_overrun && st.rxne_irq_armed;
            end
            default:
            begin
                st = state;
            end
        endcase

        r.tx_busy = st.tx_active;
        r.rx_busy = st.rx_active;

        state_next = st;
        result     = r;
    end

endmodule
